/* rtl/bcc_pkg.sv */
// shared types and constants for the bcd calendar clock
// no dependencies; imported by every other rtl and tb module
package bcc_pkg;

   // whole calendar state, one packed bcd byte per field plus weekday
   typedef struct packed {
      logic [2:0] weekday;
      logic [7:0] year;
      logic [7:0] month;
      logic [7:0] day;
      logic [7:0] hour;
      logic [7:0] min;
      logic [7:0] sec;
   } time_type;

   localparam int SET_WORD_W = 31;
   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 56;

   // item kinds carried on req_tuser
   localparam logic KIND_TICK = 1'b0;
   localparam logic KIND_SET  = 1'b1;

   // state after reset: 23:59:50 on 31 dec 2020, weekday 7
   localparam logic [7:0] RST_SEC     = 8'h50;
   localparam logic [7:0] RST_MIN     = 8'h59;
   localparam logic [7:0] RST_HOUR    = 8'h23;
   localparam logic [7:0] RST_DAY     = 8'h31;
   localparam logic [7:0] RST_MONTH   = 8'h12;
   localparam logic [7:0] RST_YEAR    = 8'h20;
   localparam logic [2:0] RST_WEEKDAY = 3'd7;

   // bcd field ranges
   localparam logic [7:0] SEC_MAX   = 8'h59;
   localparam logic [7:0] MIN_MAX   = 8'h59;
   localparam logic [7:0] HOUR_MAX  = 8'h23;
   localparam logic [7:0] WDAY_MIN  = 8'h01;
   localparam logic [7:0] WDAY_MAX  = 8'h07;
   localparam logic [7:0] DAY_MIN   = 8'h01;
   localparam logic [7:0] MONTH_MIN = 8'h01;
   localparam logic [7:0] MONTH_MAX = 8'h12;
   localparam logic [7:0] YEAR_MAX  = 8'h99;
   localparam logic [7:0] BCD_ZERO  = 8'h00;

   // month lengths in bcd
   localparam logic [7:0] LEN_31 = 8'h31;
   localparam logic [7:0] LEN_30 = 8'h30;
   localparam logic [7:0] LEN_29 = 8'h29;
   localparam logic [7:0] LEN_28 = 8'h28;

   // bcd month codes
   localparam logic [7:0] MON_FEB = 8'h02;
   localparam logic [7:0] MON_APR = 8'h04;
   localparam logic [7:0] MON_JUN = 8'h06;
   localparam logic [7:0] MON_SEP = 8'h09;
   localparam logic [7:0] MON_NOV = 8'h11;

endpackage

/* rtl/bcd_calendar_clock_unit.sv */
// top level of the bcd calendar clock: input register, next-time logic, time register
// depends on bcc_pkg and bcc_next_time
//
// usage
//   req channel: one word per item. req_tuser[0] selects the kind, 0 = one-second
//   tick, 1 = load. on a load req_tdata[30:0] holds the binary time
//   sec[5:0] min[11:6] hour[16:12] day[21:17] month[25:22] year[30:26];
//   on a tick req_tdata is ignored.
//   rsp channel: one word per item with the whole calendar after that item,
//   bcd seconds up to years plus the 3-bit weekday.
// path: an accepted req word passes through the input register, then the time
//   register, where rsp_tvalid rises.
// throughput: one word per cycle unless rsp is held off; the time register is updated
//   and read back through the combinational carry chain; ticks may be back to back.
// reset: the calendar goes to 23:59:50, 31 dec 2020, weekday 7, and both
//   stages empty. no clearing pass.
// stall: while rsp is held off the time register holds the shown word, the
//   input register keeps one more word and req_tready drops only when both
//   stages are full.
module bcd_calendar_clock_unit
   import bcc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // set_word[30:0], zero pad [31]
   input  logic [0:0]            req_tuser,  // kind[0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata   // sec[7:0] min[15:8] hour[23:16] day[31:24]
                                             // month[39:32] year[47:40] weekday[50:48]
                                             // zero pad [55:51]
);

   // input register stage
   logic                  in_valid_ff, in_valid_in;
   logic                  in_kind_ff;
   logic [SET_WORD_W-1:0] in_word_ff;

   // calendar state doubles as the result register
   time_type time_ff, time_in;
   logic     rsp_valid_ff, rsp_valid_in;

   logic advance;  // input stage moves into the time register
   logic take;     // req word accepted

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign take       = req_tvalid && req_tready;

   assign in_valid_in  = take || (in_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   bcc_next_time u_next (
      .kind     (in_kind_ff),
      .set_word (in_word_ff),
      .cur      (time_ff),
      .nxt      (time_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload of the input stage, loaded on acceptance only
   always_ff @(posedge clock) begin
      if (take) begin
         in_kind_ff <= req_tuser[0];
         in_word_ff <= req_tdata[SET_WORD_W-1:0];
      end
   end

   // calendar state, reset to its start value
   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff.sec     <= RST_SEC;
         time_ff.min     <= RST_MIN;
         time_ff.hour    <= RST_HOUR;
         time_ff.day     <= RST_DAY;
         time_ff.month   <= RST_MONTH;
         time_ff.year    <= RST_YEAR;
         time_ff.weekday <= RST_WEEKDAY;
      end else if (advance) begin
         time_ff <= time_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, time_ff.weekday, time_ff.year, time_ff.month,
                        time_ff.day, time_ff.hour, time_ff.min, time_ff.sec};

endmodule

/* rtl/bcc_next_time.sv */
// next-state logic of the calendar clock: tick carry chain and set decode
// depends on bcc_pkg (time_type, ranges, month codes)
module bcc_next_time
   import bcc_pkg::*;
(
   input  logic                  kind,
   input  logic [SET_WORD_W-1:0] set_word,
   input  time_type              cur,
   output time_type              nxt
);

   // force into range, wrap at max with carry, else bcd increment; {carry, value}
   function automatic logic [8:0] bcd_step(input logic [7:0] v, input logic [7:0] lo,
                                           input logic [7:0] hi);
      logic [7:0] x;
      logic [7:0] y;
      x = ((v < lo) || (v > hi)) ? lo : v;
      y = x + 8'd1;
      if (y[3:0] > 4'd9) begin
         y = y + 8'd6;
      end
      if (x == hi) begin
         return {1'b1, lo};
      end
      return {1'b0, y};
   endfunction

   // binary 0..63 to two bcd digits; tens by reciprocal multiply (13/128)
   function automatic logic [7:0] to_bcd(input logic [5:0] v);
      logic [12:0] p;
      logic [3:0]  tens;
      logic [6:0]  ones;
      p    = 13'(v) * 13'd13;
      tens = 4'(p >> 7);
      ones = 7'(v) - 7'(tens) * 7'd10;
      return {tens, ones[3:0]};
   endfunction

   // floor(23 * m / 9) for m in 0..15
   function automatic logic [5:0] month_term(input logic [3:0] m);
      case (m)
         4'd0:    return 6'd0;
         4'd1:    return 6'd2;
         4'd2:    return 6'd5;
         4'd3:    return 6'd7;
         4'd4:    return 6'd10;
         4'd5:    return 6'd12;
         4'd6:    return 6'd15;
         4'd7:    return 6'd17;
         4'd8:    return 6'd20;
         4'd9:    return 6'd23;
         4'd10:   return 6'd25;
         4'd11:   return 6'd28;
         4'd12:   return 6'd30;
         4'd13:   return 6'd33;
         4'd14:   return 6'd35;
         default: return 6'd38;
      endcase
   endfunction

   logic [5:0]  w_sec, w_min;
   logic [4:0]  w_hour, w_day, w_year;
   logic [3:0]  w_month;
   logic [6:0]  wd_sum;
   logic [13:0] wd_prod;
   logic [6:0]  wd_quot;
   logic [6:0]  wd_rem;
   logic [7:0]  month_len;
   logic [1:0]  leap_mod;
   logic [8:0]  st;
   time_type    tick_t;
   time_type    set_t;

   assign w_sec   = set_word[5:0];
   assign w_min   = set_word[11:6];
   assign w_hour  = set_word[16:12];
   assign w_day   = set_word[21:17];
   assign w_month = set_word[25:22];
   assign w_year  = set_word[30:26];

   // weekday of the loaded date, 0 = sunday; century terms folded into constants
   always_comb begin
      if (w_month < 4'd3) begin
         wd_sum = 7'(month_term(w_month)) + 7'(w_day) + 7'(w_year)
                + 7'((6'(w_year) + 6'd3) >> 2) + 7'd3;
      end else begin
         wd_sum = 7'(month_term(w_month)) + 7'(w_day) + 7'(w_year)
                + 7'(w_year >> 2) + 7'd2;
      end
      // mod 7 by reciprocal 73/512, low by at most one
      wd_prod = 14'(wd_sum) * 14'd73;
      wd_quot = 7'(wd_prod >> 9);
      wd_rem  = wd_sum - 7'(wd_quot * 7'd7);
      if (wd_rem >= 7'd7) begin
         wd_rem = wd_rem - 7'd7;
      end
   end

   always_comb begin
      set_t.sec     = to_bcd(w_sec);
      set_t.min     = to_bcd(w_min);
      set_t.hour    = to_bcd({1'b0, w_hour});
      set_t.day     = to_bcd({1'b0, w_day});
      set_t.month   = to_bcd({2'b00, w_month});
      set_t.year    = to_bcd({1'b0, w_year});
      set_t.weekday = wd_rem[2:0];
   end

   // month length from the month and year held before the tick
   assign leap_mod = 2'({cur.year[7:4], 1'b0} + {1'b0, cur.year[3:0]});

   always_comb begin
      case (cur.month)
         MON_APR, MON_JUN, MON_SEP, MON_NOV: month_len = LEN_30;
         MON_FEB:  month_len = (leap_mod == 2'd0) ? LEN_29 : LEN_28;
         default:  month_len = LEN_31;
      endcase
   end

   // carry chain, each field steps only on the carry of the one below
   always_comb begin
      tick_t = cur;
      st = bcd_step(cur.sec, BCD_ZERO, SEC_MAX);
      tick_t.sec = st[7:0];
      if (st[8]) begin
         st = bcd_step(cur.min, BCD_ZERO, MIN_MAX);
         tick_t.min = st[7:0];
         if (st[8]) begin
            st = bcd_step(cur.hour, BCD_ZERO, HOUR_MAX);
            tick_t.hour = st[7:0];
            if (st[8]) begin
               st = bcd_step({5'b0, cur.weekday}, WDAY_MIN, WDAY_MAX);
               tick_t.weekday = st[2:0];
               st = bcd_step(cur.day, DAY_MIN, month_len);
               tick_t.day = st[7:0];
               if (st[8]) begin
                  st = bcd_step(cur.month, MONTH_MIN, MONTH_MAX);
                  tick_t.month = st[7:0];
                  if (st[8]) begin
                     st = bcd_step(cur.year, BCD_ZERO, YEAR_MAX);
                     tick_t.year = st[7:0];
                  end
               end
            end
         end
      end
   end

   assign nxt = (kind == KIND_SET) ? set_t : tick_t;

endmodule

/* rtl/bcc_checker.sv */
// port-level checks of the bcd calendar clock, bound to the top level
// depends on bcc_pkg and bcd_calendar_clock_unit
module bcc_checker
   import bcc_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata   // sec, min, hour, day, month, year, weekday
);

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid after reset");

   // a stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp word changed under stall");

   // with no result waiting the block always takes a word
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("req_tready low with empty output");

   // every bcd field shows a decimal low digit and the pad stays zero
   a_bcd_digits: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[3:0] <= 4'd9) && (rsp_tdata[11:8] <= 4'd9)
         && (rsp_tdata[19:16] <= 4'd9) && (rsp_tdata[27:24] <= 4'd9)
         && (rsp_tdata[35:32] <= 4'd9) && (rsp_tdata[43:40] <= 4'd9)
         && (rsp_tdata[55:51] == 5'd0))
      else $error("non-decimal digit in rsp word");

endmodule

bind bcd_calendar_clock_unit bcc_checker u_bcc_checker (.*);

/* tb/bcc_checker.sv */
// checker for the bcd calendar clock: watches the req and rsp channels,
// predicts the calendar after every accepted req word and compares rsp words
// depends on bcc_pkg for the time layout, item kinds and bcd constants
`timescale 1ns / 1ps

module bcc_scoreboard
   import bcc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,  // set_word[30:0], zero pad [31]
   input  logic [0:0]            req_tuser,  // kind[0]
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,  // sec min hour day month year weekday, pad
   output int                    fail_count,
   output int                    pending
);

   localparam time_type RESET_TIME = '{weekday: RST_WEEKDAY, year: RST_YEAR,
                                       month: RST_MONTH, day: RST_DAY, hour: RST_HOUR,
                                       min: RST_MIN, sec: RST_SEC};

   time_type calendar = RESET_TIME;
   time_type future_times[$];

   // one bcd field step: {carry, next value}
   function automatic logic [8:0] step_bcd(input logic [7:0] v, input logic [7:0] lo,
                                           input logic [7:0] hi);
      logic [7:0] x;
      x = v;
      if (x < lo || x > hi) x = lo;
      if (x == hi) return {1'b1, lo};
      x = x + 8'd1;
      if (x[3:0] > 4'd9) x = x + 8'd6;
      return {1'b0, x};
   endfunction

   function automatic int unsigned bcd_value(input logic [7:0] b);
      return b[7:4] * 10 + b[3:0];
   endfunction

   function automatic logic [7:0] to_bcd(input int unsigned v);
      return 8'(((v / 10) % 16) * 16 + v % 10);
   endfunction

   function automatic logic [7:0] month_days(input logic [7:0] yr, input logic [7:0] mo);
      case (mo)
         MON_APR, MON_JUN, MON_SEP, MON_NOV: return LEN_30;
         MON_FEB: return (bcd_value(yr) % 4 == 0) ? LEN_29 : LEN_28;
         default: return LEN_31;
      endcase
   endfunction

   function automatic time_type tick_time(input time_type t);
      time_type n;
      logic [8:0] r;
      logic carry;
      n = t;
      r = step_bcd(n.sec, BCD_ZERO, SEC_MAX);
      n.sec = r[7:0];
      carry = r[8];
      if (carry) begin
         r = step_bcd(n.min, BCD_ZERO, MIN_MAX);
         n.min = r[7:0];
         carry = r[8];
      end
      if (carry) begin
         r = step_bcd(n.hour, BCD_ZERO, HOUR_MAX);
         n.hour = r[7:0];
         carry = r[8];
      end
      if (carry) begin
         r = step_bcd({5'd0, n.weekday}, WDAY_MIN, WDAY_MAX);
         n.weekday = r[2:0];
         // day wraps at the length of the month shown before this tick
         r = step_bcd(n.day, DAY_MIN, month_days(t.year, t.month));
         n.day = r[7:0];
         carry = r[8];
      end
      if (carry) begin
         r = step_bcd(n.month, MONTH_MIN, MONTH_MAX);
         n.month = r[7:0];
         carry = r[8];
      end
      if (carry) begin
         r = step_bcd(n.year, BCD_ZERO, YEAR_MAX);
         n.year = r[7:0];
      end
      return n;
   endfunction

   function automatic time_type load_time(input logic [30:0] w);
      time_type n;
      int unsigned d, m, y;
      n.sec   = to_bcd(w[5:0]);
      n.min   = to_bcd(w[11:6]);
      n.hour  = to_bcd(w[16:12]);
      n.day   = to_bcd(w[21:17]);
      n.month = to_bcd(w[25:22]);
      n.year  = to_bcd(w[30:26]);
      d = bcd_value(n.day);
      m = bcd_value(n.month);
      y = 2000 + bcd_value(n.year);
      if (m < 3) begin
         d = d + y;
         y = y - 1;
      end else begin
         d = d + y - 2;
      end
      n.weekday = 3'((23 * m / 9 + d + 4 + y / 4 - y / 100 + y / 400) % 7);
      return n;
   endfunction

   task automatic check_field(input string name, input logic [7:0] want,
                              input logic [7:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         fail_count = fail_count + 1;
      end
   endtask

   always @(posedge clock) begin
      time_type want, got;
      if (reset) begin
         calendar = RESET_TIME;
         future_times.delete();
      end else begin
         // rsp first, so a word with nothing waiting is never hidden by a new push
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[$bits(time_type)-1:0];
            if (future_times.size() == 0) begin
               $display("%0t: unexpected rsp word, expected none, actual %h",
                        $time, rsp_tdata);
               fail_count = fail_count + 1;
            end else begin
               want = future_times.pop_front();
               check_field("sec", want.sec, got.sec);
               check_field("min", want.min, got.min);
               check_field("hour", want.hour, got.hour);
               check_field("day", want.day, got.day);
               check_field("month", want.month, got.month);
               check_field("year", want.year, got.year);
               check_field("weekday", {5'd0, want.weekday}, {5'd0, got.weekday});
               check_field("pad", 8'd0, 8'(rsp_tdata[RSP_DATA_W-1:$bits(time_type)]));
            end
         end
         if (req_tvalid && req_tready) begin
            if (req_tuser[0] == KIND_SET) calendar = load_time(req_tdata[SET_WORD_W-1:0]);
            else calendar = tick_time(calendar);
            future_times.push_back(calendar);
         end
      end
      pending = future_times.size();
   end

endmodule

/* tb/tb.sv */
// top of the bcd calendar clock regression: clock, reset, req stimulus,
// random rsp backpressure and the final verdict
// depends on bcc_pkg, bcd_calendar_clock_unit and bcc_scoreboard
`timescale 1ns / 1ps

module tb;
   import bcc_pkg::*;

   // generous ceiling on the run, checked by the watchdog
   localparam int CYCLE_LIMIT = 200000;
   // drain time after the last expected word
   localparam int DRAIN_CYCLES = 10;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;   // set_word[30:0], zero pad [31]
   logic [0:0]            req_tuser = '0;   // kind[0]
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;        // sec[7:0] min[15:8] hour[23:16] day[31:24]
                                            // month[39:32] year[47:40] weekday[50:48]

   int fail_count;
   int pending;
   int cycle_count = 0;
   int unsigned items_sent = 0;

   // idle odds in percent for each side, changed between phases
   int unsigned send_idle_pct = 36;
   int unsigned recv_idle_pct = 69;

   bcd_calendar_clock_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   bcc_scoreboard u_scoreboard (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // receiver backpressure, one roll per cycle
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("bcd_calendar_clock_unit regression: fail");
         $finish;
      end
   end

   // binary set word: sec[5:0] min[11:6] hour[16:12] day[21:17] month[25:22] year[30:26]
   function automatic logic [30:0] pack_time(input int unsigned s, input int unsigned mi,
                                             input int unsigned h, input int unsigned d,
                                             input int unsigned mo, input int unsigned y);
      return {5'(y), 4'(mo), 5'(d), 5'(h), 6'(mi), 6'(s)};
   endfunction

   // present one word, with random idle cycles ahead of it; ready is sampled
   // at the falling edge so the handshake never races the drivers
   task automatic send_item(input logic kind, input logic [30:0] word);
      logic took;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {1'b0, word};
      do begin
         @(negedge clock);
         took = req_tready;
         @(posedge clock);
      end while (!took);
      items_sent = items_sent + 1;
   endtask

   // load close to a rollover, some fields at times out of range, then a run of ticks through it
   task automatic rollover_run();
      int unsigned n;
      send_item(KIND_SET, pack_time($urandom_range(55, 59),
                                    $urandom_range(3) != 0 ? 59 : $urandom_range(63),
                                    $urandom_range(3) != 0 ? 23 : $urandom_range(31),
                                    $urandom_range(3) != 0 ? $urandom_range(27, 31)
                                                           : $urandom_range(31),
                                    $urandom_range(4) != 0 ? $urandom_range(1, 12)
                                                           : $urandom_range(15),
                                    $urandom_range(31)));
      n = $urandom_range(1, 12);
      repeat (n) send_item(KIND_TICK, 31'($urandom));
   endtask

   task automatic random_phase(input int unsigned count);
      int unsigned stop;
      int unsigned pick;
      stop = items_sent + count;
      while (items_sent < stop) begin
         pick = $urandom_range(99);
         if (pick < 70) rollover_run();
         else if (pick < 85) send_item(KIND_SET, 31'($urandom));  // raw word, any field
         else send_item(KIND_TICK, 31'($urandom));
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // ---- directed part ----
      // from the reset time, ten ticks roll 31 dec 2020 into 2021 and wrap weekday 7
      repeat (10) send_item(KIND_TICK, '0);
      // all-zero word: day and month below range
      send_item(KIND_SET, '0);
      send_item(KIND_TICK, '0);
      // all-ones word: sec, min, hour and month above range
      send_item(KIND_SET, '1);
      send_item(KIND_TICK, '0);
      // end of february, common year then leap year
      send_item(KIND_SET, pack_time(59, 59, 23, 28, 2, 23));
      send_item(KIND_TICK, '0);
      send_item(KIND_SET, pack_time(59, 59, 23, 28, 2, 24));
      send_item(KIND_TICK, '0);
      // thirty-day month
      send_item(KIND_SET, pack_time(59, 59, 23, 30, 4, 7));
      send_item(KIND_TICK, '0);
      // new year from the highest loadable year
      send_item(KIND_SET, pack_time(59, 59, 23, 31, 12, 31));
      send_item(KIND_TICK, '0);
      // invalid month counts 31 days, then gets forced to january and steps
      send_item(KIND_SET, pack_time(59, 59, 23, 31, 13, 5));
      send_item(KIND_TICK, '0);
      // a sunday loads weekday 0, the next day steps it to 2
      send_item(KIND_SET, pack_time(59, 59, 23, 2, 1, 0));
      send_item(KIND_TICK, '0);

      // ---- random part, three idle phases ----
      random_phase(400);
      send_idle_pct = 69;
      recv_idle_pct = 36;
      random_phase(400);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      random_phase(425);

      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);

      if (fail_count == 0 && pending == 0) begin
         $display("bcd_calendar_clock_unit regression: pass");
      end else begin
         $display("bcd_calendar_clock_unit regression: fail");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/bcc_pkg.sv
rtl/bcc_next_time.sv
rtl/bcd_calendar_clock_unit.sv
rtl/bcc_checker.sv
tb/bcc_checker.sv
tb/tb.sv
